/* hw/rtl/kolt_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// kolt_pkg: keyed ordered list table types and codes
// Request, response and entry layouts, request kinds and status codes.
// ----------------------------------------------------------------------------
package kolt_pkg;

	typedef struct packed {
		logic [2:0]  kind;
		logic [7:0]  position;
		logic [31:0] customer_key;
		logic [63:0] customer_name;
	} kolt_req_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [6:0]  found_index;
		logic [7:0]  entry_total;
		logic [31:0] read_key;
		logic [63:0] read_name;
	} kolt_rsp_t;

	typedef struct packed {
		logic [31:0] key;
		logic [63:0] name;
	} kolt_entry_t;

	localparam logic [2:0] KIND_APPEND    = 3'd0;
	localparam logic [2:0] KIND_INSERT    = 3'd1;
	localparam logic [2:0] KIND_DEL_KEY   = 3'd2;
	localparam logic [2:0] KIND_DEL_NAME  = 3'd3;
	localparam logic [2:0] KIND_FIND_KEY  = 3'd4;
	localparam logic [2:0] KIND_FIND_NAME = 3'd5;
	localparam logic [2:0] KIND_READ      = 3'd6;
	localparam logic [2:0] KIND_CLEAR     = 3'd7;

	localparam logic [2:0] STATUS_OK        = 3'd0;
	localparam logic [2:0] STATUS_FULL      = 3'd1;
	localparam logic [2:0] STATUS_DUP_KEY   = 3'd2;
	localparam logic [2:0] STATUS_BAD_POS   = 3'd3;
	localparam logic [2:0] STATUS_EMPTY     = 3'd4;
	localparam logic [2:0] STATUS_NOT_FOUND = 3'd5;

	localparam logic [7:0] CAPACITY_RESET = 8'd100;

endpackage
`default_nettype wire

/* hw/rtl/keyed_ordered_list_table.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// keyed_ordered_list_table: ordered list of keyed entries
// Requests arrive on req (valid/ready), one response per request leaves on
// rsp (valid/ready). The capacity register is written through cfg_valid and
// cfg_data; cfg_ready is always high and a write is meant for an idle block.
// Entries live in a simple dual-port memory of MAX_ENTRIES rows, with one
// read and one write per cycle. A small sequencer walks that memory: a search
// issues one read a cycle and compares the registered data with one shared
// key/name comparator, and a shift moves one row a cycle.
// Read and clear do not walk the memory; find and delete scan the stored
// entries row by row up to a match, append and insert scan them all for a
// duplicate key, and delete and insert then shift the rows behind the entry.
// req_ready is high only while the sequencer is idle. A finished response sits
// in an output register; the next request is taken while it waits, and the
// sequencer holds its following response until rsp_ready frees that register.
// Reset empties the list and sets the capacity to 100; memory contents are
// not cleared and are never read before being written.
// ----------------------------------------------------------------------------
module keyed_ordered_list_table #(
	parameter int MAX_ENTRIES = 128
) (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire                         req_valid,
	output logic                        req_ready,
	input  wire kolt_pkg::kolt_req_t    req,
	output logic                        rsp_valid,
	input  wire                         rsp_ready,
	output kolt_pkg::kolt_rsp_t         rsp,
	input  wire                         cfg_valid,
	output logic                        cfg_ready,
	input  wire [7:0]                   cfg_data
);

	localparam int IW = $clog2(MAX_ENTRIES);
	localparam int CW = $clog2(MAX_ENTRIES + 1);
	localparam int PW = (CW > 8) ? CW : 8;

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_DECODE = 3'd1;
	localparam logic [2:0] S_SCAN   = 3'd2;
	localparam logic [2:0] S_SHIFT  = 3'd3;
	localparam logic [2:0] S_FIN    = 3'd4;
	localparam logic [2:0] S_READ   = 3'd5;
	localparam logic [2:0] S_RDWAIT = 3'd6;
	localparam logic [2:0] S_DONE   = 3'd7;

	// control state
	logic [2:0]  state_q, state_d;
	logic [CW-1:0] count_q, count_d;
	logic [7:0]  cap_q;
	logic        rsp_valid_q, rsp_valid_d;
	logic        cmp_vld_q, cmp_vld_d;
	logic        wr_vld_q, wr_vld_d;

	// datapath registers
	kolt_pkg::kolt_req_t req_q, req_d;
	kolt_pkg::kolt_rsp_t rsp_q, rsp_d;
	logic [IW-1:0] idx_q, idx_d;
	logic [IW-1:0] sh_addr_q, sh_addr_d;
	logic [IW-1:0] wr_addr_q, wr_addr_d;
	logic [IW-1:0] cmp_idx_q, cmp_idx_d;
	logic [CW-1:0] scan_addr_q, scan_addr_d;
	logic [CW-1:0] mv_q, mv_d;
	logic [2:0]    st_q, st_d;
	logic [IW-1:0] fnd_q, fnd_d;
	logic          up_q, up_d;

	// entry memory
	kolt_pkg::kolt_entry_t mem_q [MAX_ENTRIES];
	kolt_pkg::kolt_entry_t rdata_q;
	logic                  rd_en;
	logic [IW-1:0]         rd_addr;
	logic                  wr_en;
	logic [IW-1:0]         wr_addr;
	kolt_pkg::kolt_entry_t wr_data;

	logic [PW-1:0] pos_w, cnt_w, cap_w;
	logic          full, use_key, hit, scan_more;

	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;
	assign cfg_ready = 1'b1;

	assign pos_w = PW'(req_q.position);
	assign cnt_w = PW'(count_q);
	assign cap_w = PW'(cap_q);
	assign full  = (cnt_w >= cap_w) || (count_q == CW'(MAX_ENTRIES));

	assign use_key = (req_q.kind == kolt_pkg::KIND_APPEND) ||
		(req_q.kind == kolt_pkg::KIND_INSERT) ||
		(req_q.kind == kolt_pkg::KIND_DEL_KEY) ||
		(req_q.kind == kolt_pkg::KIND_FIND_KEY);

	// shared comparator
	assign hit = cmp_vld_q && (use_key ? (rdata_q.key == req_q.customer_key)
		: (rdata_q.name == req_q.customer_name));
	assign scan_more = (scan_addr_q < count_q);

	always_comb begin
		state_d     = state_q;
		count_d     = count_q;
		rsp_valid_d = rsp_valid_q;
		cmp_vld_d   = cmp_vld_q;
		wr_vld_d    = wr_vld_q;
		req_d       = req_q;
		rsp_d       = rsp_q;
		idx_d       = idx_q;
		sh_addr_d   = sh_addr_q;
		wr_addr_d   = wr_addr_q;
		cmp_idx_d   = cmp_idx_q;
		scan_addr_d = scan_addr_q;
		mv_d        = mv_q;
		st_d        = st_q;
		fnd_d       = fnd_q;
		up_d        = up_q;
		rd_en       = 1'b0;
		rd_addr     = '0;
		wr_en       = 1'b0;
		wr_addr     = '0;
		wr_data     = '0;

		if (rsp_valid_q && rsp_ready) begin
			rsp_valid_d = 1'b0;
		end

		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					req_d   = req;
					st_d    = kolt_pkg::STATUS_OK;
					fnd_d   = '0;
					state_d = S_DECODE;
				end
			end
			S_DECODE: begin
				scan_addr_d = '0;
				cmp_vld_d   = 1'b0;
				case (req_q.kind)
					kolt_pkg::KIND_APPEND, kolt_pkg::KIND_INSERT: begin
						if (full) begin
							st_d    = kolt_pkg::STATUS_FULL;
							state_d = S_DONE;
						end else if (req_q.kind == kolt_pkg::KIND_INSERT &&
							(pos_w == '0 || (pos_w - PW'(1)) > cnt_w)) begin
							st_d    = kolt_pkg::STATUS_BAD_POS;
							state_d = S_DONE;
						end else begin
							idx_d   = (req_q.kind == kolt_pkg::KIND_INSERT) ?
								IW'(pos_w - PW'(1)) : IW'(count_q);
							state_d = S_SCAN;
						end
					end
					kolt_pkg::KIND_READ: begin
						if (count_q == '0) begin
							st_d    = kolt_pkg::STATUS_EMPTY;
							state_d = S_DONE;
						end else if (pos_w == '0 || pos_w > cnt_w) begin
							st_d    = kolt_pkg::STATUS_BAD_POS;
							state_d = S_DONE;
						end else begin
							idx_d   = IW'(pos_w - PW'(1));
							state_d = S_READ;
						end
					end
					kolt_pkg::KIND_CLEAR: begin
						count_d = '0;
						state_d = S_DONE;
					end
					default: begin
						if (count_q == '0) begin
							st_d    = kolt_pkg::STATUS_EMPTY;
							state_d = S_DONE;
						end else begin
							state_d = S_SCAN;
						end
					end
				endcase
			end
			S_SCAN: begin
				if (hit) begin
					cmp_vld_d = 1'b0;
					case (req_q.kind)
						kolt_pkg::KIND_APPEND, kolt_pkg::KIND_INSERT: begin
							st_d    = kolt_pkg::STATUS_DUP_KEY;
							state_d = S_DONE;
						end
						kolt_pkg::KIND_DEL_KEY, kolt_pkg::KIND_DEL_NAME: begin
							fnd_d     = cmp_idx_q;
							up_d      = 1'b0;
							mv_d      = count_q - CW'(1) - CW'(cmp_idx_q);
							sh_addr_d = cmp_idx_q + IW'(1);
							wr_vld_d  = 1'b0;
							state_d   = S_SHIFT;
						end
						default: begin
							fnd_d   = cmp_idx_q;
							state_d = S_DONE;
						end
					endcase
				end else if (scan_more) begin
					rd_en       = 1'b1;
					rd_addr     = scan_addr_q[IW-1:0];
					cmp_idx_d   = scan_addr_q[IW-1:0];
					cmp_vld_d   = 1'b1;
					scan_addr_d = scan_addr_q + CW'(1);
				end else if (cmp_vld_q) begin
					cmp_vld_d = 1'b0;
				end else begin
					if (req_q.kind == kolt_pkg::KIND_APPEND ||
						req_q.kind == kolt_pkg::KIND_INSERT) begin
						up_d      = 1'b1;
						mv_d      = count_q - CW'(idx_q);
						sh_addr_d = IW'(count_q - CW'(1));
						wr_vld_d  = 1'b0;
						state_d   = S_SHIFT;
					end else begin
						st_d    = kolt_pkg::STATUS_NOT_FOUND;
						state_d = S_DONE;
					end
				end
			end
			S_SHIFT: begin
				if (wr_vld_q) begin
					wr_en   = 1'b1;
					wr_addr = wr_addr_q;
					wr_data = rdata_q;
				end
				if (mv_q != '0) begin
					rd_en     = 1'b1;
					rd_addr   = sh_addr_q;
					wr_addr_d = up_q ? sh_addr_q + IW'(1) : sh_addr_q - IW'(1);
					sh_addr_d = up_q ? sh_addr_q - IW'(1) : sh_addr_q + IW'(1);
					wr_vld_d  = 1'b1;
					mv_d      = mv_q - CW'(1);
				end else begin
					wr_vld_d = 1'b0;
					state_d  = S_FIN;
				end
			end
			S_FIN: begin
				if (up_q) begin
					wr_en        = 1'b1;
					wr_addr      = idx_q;
					wr_data.key  = req_q.customer_key;
					wr_data.name = req_q.customer_name;
					count_d      = count_q + CW'(1);
				end else begin
					count_d = count_q - CW'(1);
				end
				state_d = S_DONE;
			end
			S_READ: begin
				rd_en   = 1'b1;
				rd_addr = idx_q;
				state_d = S_RDWAIT;
			end
			S_RDWAIT: begin
				state_d = S_DONE;
			end
			S_DONE: begin
				if (!rsp_valid_q || rsp_ready) begin
					rsp_valid_d       = 1'b1;
					rsp_d.status      = st_q;
					rsp_d.found_index = 7'(fnd_q);
					rsp_d.entry_total = 8'(count_q);
					if (req_q.kind == kolt_pkg::KIND_READ &&
						st_q == kolt_pkg::STATUS_OK) begin
						rsp_d.read_key  = rdata_q.key;
						rsp_d.read_name = rdata_q.name;
					end else begin
						rsp_d.read_key  = '0;
						rsp_d.read_name = '0;
					end
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			cap_q       <= kolt_pkg::CAPACITY_RESET;
			rsp_valid_q <= 1'b0;
			cmp_vld_q   <= 1'b0;
			wr_vld_q    <= 1'b0;
		end else begin
			state_q     <= state_d;
			count_q     <= count_d;
			rsp_valid_q <= rsp_valid_d;
			cmp_vld_q   <= cmp_vld_d;
			wr_vld_q    <= wr_vld_d;
			if (cfg_valid) begin
				cap_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk) begin
		req_q       <= req_d;
		rsp_q       <= rsp_d;
		idx_q       <= idx_d;
		sh_addr_q   <= sh_addr_d;
		wr_addr_q   <= wr_addr_d;
		cmp_idx_q   <= cmp_idx_d;
		scan_addr_q <= scan_addr_d;
		mv_q        <= mv_d;
		st_q        <= st_d;
		fnd_q       <= fnd_d;
		up_q        <= up_d;
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rdata_q <= mem_q[rd_addr];
		end
	end

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_ENTRIES))
		else $error("entry count above table depth");

	a_count_change: assert property (@(posedge clk) disable iff (!arst_n)
		!(state_q == S_FIN || state_q == S_DECODE) |=> $stable(count_q))
		else $error("entry count changed outside finish or clear");

	a_write_window: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (state_q == S_SHIFT || state_q == S_FIN))
		else $error("memory write outside shift or finish");

	a_scan_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN && cmp_vld_q) |-> (CW'(cmp_idx_q) < count_q))
		else $error("search compared a row beyond the list");

	a_rsp_issue: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE && (!rsp_valid_q || rsp_ready)) |=>
		(rsp_valid && state_q == S_IDLE))
		else $error("finished request did not produce a response transfer");
`endif

endmodule
`default_nettype wire

/* verif/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: keyed ordered list table testbench
// Drives requests and capacity writes into keyed_ordered_list_table, predicts
// each response from a behavioral copy of the list and compares every field.
// A directed opening hits the empty, full, bad position, duplicate key and
// not found cases; random phases then fill the list to its depth and work it
// under several capacity settings, with random gaps and stalls on both sides.
// ----------------------------------------------------------------------------
module tb;

	localparam int DEPTH      = 128;
	localparam int PLAN       = 0;
	localparam int LIVE       = 1;
	localparam int IDLE_LIMIT = 4000;
	localparam int TAIL       = 300;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                req_valid = 1'b0;
	logic                req_ready;
	kolt_pkg::kolt_req_t req = '0;
	logic                rsp_valid;
	logic                rsp_ready = 1'b0;
	kolt_pkg::kolt_rsp_t rsp;
	logic                cfg_valid = 1'b0;
	logic                cfg_ready;
	logic [7:0]          cfg_data = '0;

	logic req_fire = 1'b0;
	logic rsp_fire = 1'b0;
	logic cfg_fire = 1'b0;

	// two copies of the list: PLAN runs ahead at generation, LIVE at transfer
	logic [31:0] list_keys [2][DEPTH];
	logic [63:0] list_names [2][DEPTH];
	int          list_count [2] = '{0, 0};
	logic [7:0]  list_cap [2] = '{kolt_pkg::CAPACITY_RESET, kolt_pkg::CAPACITY_RESET};

	kolt_pkg::kolt_req_t pending_req_q [$];
	kolt_pkg::kolt_rsp_t expected_rsp_q [$];
	logic [63:0]         name_pool [8];

	int issued_total = 0;
	int accepted_total = 0;
	int checked_total = 0;
	int error_count = 0;
	int idle_cycles = 0;
	int capacity_writes = 0;
	int longest_list = 0;
	int status_seen [8] = '{default: 0};
	int req_gap = 0;
	int rsp_wait = 0;
	bit req_calm = 1'b0;
	bit rsp_calm = 1'b0;

	keyed_ordered_list_table #(
		.MAX_ENTRIES(DEPTH)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	function automatic int first_key_match(input int v, input logic [31:0] k);
		int i;
		for (i = 0; i < list_count[v]; i++)
			if (list_keys[v][i] == k)
				return i;
		return list_count[v];
	endfunction

	function automatic int first_name_match(input int v, input logic [63:0] nm);
		int i;
		for (i = 0; i < list_count[v]; i++)
			if (list_names[v][i] == nm)
				return i;
		return list_count[v];
	endfunction

	function automatic kolt_pkg::kolt_rsp_t apply_request(input int v,
			input kolt_pkg::kolt_req_t r);
		kolt_pkg::kolt_rsp_t o;
		int n, lim, idx, i;
		o = '0;
		n = list_count[v];
		lim = (list_cap[v] < DEPTH) ? int'(list_cap[v]) : DEPTH;
		case (r.kind)
		kolt_pkg::KIND_APPEND, kolt_pkg::KIND_INSERT: begin
			if (n >= lim)
				o.status = kolt_pkg::STATUS_FULL;
			else if (r.kind == kolt_pkg::KIND_INSERT &&
					(r.position == 0 || int'(r.position) > n + 1))
				o.status = kolt_pkg::STATUS_BAD_POS;
			else if (first_key_match(v, r.customer_key) != n)
				o.status = kolt_pkg::STATUS_DUP_KEY;
			else begin
				idx = (r.kind == kolt_pkg::KIND_INSERT) ? int'(r.position) - 1 : n;
				for (i = n; i > idx; i--) begin
					list_keys[v][i] = list_keys[v][i - 1];
					list_names[v][i] = list_names[v][i - 1];
				end
				list_keys[v][idx] = r.customer_key;
				list_names[v][idx] = r.customer_name;
				list_count[v] = n + 1;
			end
		end
		kolt_pkg::KIND_DEL_KEY, kolt_pkg::KIND_DEL_NAME, kolt_pkg::KIND_FIND_KEY,
		kolt_pkg::KIND_FIND_NAME: begin
			if (n == 0)
				o.status = kolt_pkg::STATUS_EMPTY;
			else begin
				if (r.kind == kolt_pkg::KIND_DEL_KEY || r.kind == kolt_pkg::KIND_FIND_KEY)
					idx = first_key_match(v, r.customer_key);
				else
					idx = first_name_match(v, r.customer_name);
				if (idx == n)
					o.status = kolt_pkg::STATUS_NOT_FOUND;
				else begin
					o.found_index = 7'(idx);
					if (r.kind == kolt_pkg::KIND_DEL_KEY ||
							r.kind == kolt_pkg::KIND_DEL_NAME) begin
						for (i = idx; i + 1 < n; i++) begin
							list_keys[v][i] = list_keys[v][i + 1];
							list_names[v][i] = list_names[v][i + 1];
						end
						list_count[v] = n - 1;
					end
				end
			end
		end
		kolt_pkg::KIND_READ: begin
			if (n == 0)
				o.status = kolt_pkg::STATUS_EMPTY;
			else if (r.position == 0 || int'(r.position) > n)
				o.status = kolt_pkg::STATUS_BAD_POS;
			else begin
				o.read_key = list_keys[v][r.position - 1];
				o.read_name = list_names[v][r.position - 1];
			end
		end
		default: begin
			list_count[v] = 0;
		end
		endcase
		o.entry_total = 8'(list_count[v]);
		return o;
	endfunction

	task automatic queue_req(input logic [2:0] kind, input logic [7:0] pos,
			input logic [31:0] key, input logic [63:0] nm);
		kolt_pkg::kolt_req_t r;
		r.kind = kind;
		r.position = pos;
		r.customer_key = key;
		r.customer_name = nm;
		pending_req_q.push_back(r);
		void'(apply_request(PLAN, r));
		issued_total++;
	endtask

	task automatic drain();
		while (accepted_total != issued_total || expected_rsp_q.size() != 0)
			@(negedge clk);
	endtask

	task automatic write_capacity(input logic [7:0] value);
		drain();
		@(negedge clk);
		cfg_data <= value;
		cfg_valid <= 1'b1;
		do
			@(negedge clk);
		while (!cfg_fire);
		cfg_valid <= 1'b0;
		list_cap[PLAN] = value;
		capacity_writes++;
	endtask

	function automatic logic [2:0] pick_kind(input bit fill);
		int roll;
		roll = $urandom_range(0, 99);
		if (fill) begin
			if (roll < 40) return kolt_pkg::KIND_APPEND;
			if (roll < 88) return kolt_pkg::KIND_INSERT;
			if (roll < 91) return kolt_pkg::KIND_DEL_KEY;
			if (roll < 93) return kolt_pkg::KIND_DEL_NAME;
			if (roll < 95) return kolt_pkg::KIND_FIND_KEY;
			if (roll < 97) return kolt_pkg::KIND_FIND_NAME;
			return kolt_pkg::KIND_READ;
		end
		if (roll < 18) return kolt_pkg::KIND_APPEND;
		if (roll < 36) return kolt_pkg::KIND_INSERT;
		if (roll < 50) return kolt_pkg::KIND_DEL_KEY;
		if (roll < 60) return kolt_pkg::KIND_DEL_NAME;
		if (roll < 72) return kolt_pkg::KIND_FIND_KEY;
		if (roll < 82) return kolt_pkg::KIND_FIND_NAME;
		if (roll < 97) return kolt_pkg::KIND_READ;
		return kolt_pkg::KIND_CLEAR;
	endfunction

	function automatic logic [63:0] random_name();
		if ($urandom_range(0, 2) == 0)
			return {$urandom, $urandom};
		return name_pool[$urandom_range(0, 7)];
	endfunction

	// mostly well-formed requests aimed at live entries, some noise
	task automatic plan_random(input int items, input bit fill);
		logic [2:0]  kind;
		logic [7:0]  pos;
		logic [31:0] key;
		logic [63:0] nm;
		int k, n;
		for (k = 0; k < items; k++) begin
			n = list_count[PLAN];
			kind = pick_kind(fill);
			pos = 8'($urandom_range(0, 255));
			key = $urandom;
			nm = random_name();
			case (kind)
			kolt_pkg::KIND_APPEND, kolt_pkg::KIND_INSERT: begin
				if (n != 0 && $urandom_range(0, 99) < 12)
					key = list_keys[PLAN][$urandom_range(0, n - 1)];
				if ($urandom_range(0, 99) < 90)
					pos = 8'($urandom_range(1, n + 1));
			end
			kolt_pkg::KIND_DEL_KEY, kolt_pkg::KIND_FIND_KEY: begin
				if (n != 0 && $urandom_range(0, 99) < 80)
					key = list_keys[PLAN][$urandom_range(0, n - 1)];
			end
			kolt_pkg::KIND_DEL_NAME, kolt_pkg::KIND_FIND_NAME: begin
				if (n != 0 && $urandom_range(0, 99) < 80)
					nm = list_names[PLAN][$urandom_range(0, n - 1)];
			end
			kolt_pkg::KIND_READ: begin
				if (n != 0 && $urandom_range(0, 99) < 90)
					pos = 8'($urandom_range(1, n));
			end
			default: begin
			end
			endcase
			queue_req(kind, pos, key, nm);
		end
	endtask

	task automatic report_field(input string field, input logic [63:0] want,
			input logic [63:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
			error_count++;
		end
	endtask

	always @(negedge clk) begin : req_driver
		if (arst_n) begin
			if (req_fire)
				req_gap = req_calm ? 0 : $urandom_range(0, 4);
			if (!req_valid || req_fire) begin
				if (req_gap != 0) begin
					req_gap--;
					req_valid <= 1'b0;
				end else if (pending_req_q.size() != 0) begin
					req <= pending_req_q.pop_front();
					req_valid <= 1'b1;
					if ($urandom_range(0, 31) == 0)
						req_calm = !req_calm;
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	always @(negedge clk) begin : rsp_driver
		if (arst_n) begin
			if (rsp_fire) begin
				rsp_wait = rsp_calm ? 0 : $urandom_range(0, 4);
				if ($urandom_range(0, 31) == 0)
					rsp_calm = !rsp_calm;
			end
			if (rsp_wait != 0) begin
				rsp_wait--;
				rsp_ready <= 1'b0;
			end else begin
				rsp_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin : monitor
		kolt_pkg::kolt_rsp_t want;
		req_fire <= req_valid && req_ready;
		rsp_fire <= rsp_valid && rsp_ready;
		cfg_fire <= cfg_valid && cfg_ready;
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				list_cap[LIVE] = cfg_data;
			if (req_valid && req_ready) begin
				expected_rsp_q.push_back(apply_request(LIVE, req));
				accepted_total++;
			end
			if (rsp_valid && rsp_ready) begin
				if (expected_rsp_q.size() == 0) begin
					$display("%0t: response with none expected, expected none, actual %h",
						$time, rsp);
					error_count++;
				end else begin
					want = expected_rsp_q.pop_front();
					report_field("status", 64'(want.status), 64'(rsp.status));
					report_field("found_index", 64'(want.found_index),
						64'(rsp.found_index));
					report_field("entry_total", 64'(want.entry_total),
						64'(rsp.entry_total));
					report_field("read_key", 64'(want.read_key), 64'(rsp.read_key));
					report_field("read_name", want.read_name, rsp.read_name);
					status_seen[want.status]++;
					if (int'(want.entry_total) > longest_list)
						longest_list = int'(want.entry_total);
				end
				checked_total++;
			end
			if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (cfg_valid && cfg_ready))
				idle_cycles = 0;
			else if (++idle_cycles >= IDLE_LIMIT) begin
				$display("%0t: timeout, no transfer for %0d cycles", $time, IDLE_LIMIT);
				$display("keyed_ordered_list_table test failed");
				$finish;
			end
		end
	end

	initial begin : stimulus
		int i;
		for (i = 0; i < 8; i++)
			name_pool[i] = {$urandom, $urandom};
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// empty list, position limits, duplicates, shifts and misses
		queue_req(kolt_pkg::KIND_DEL_KEY, 8'd1, 32'd1, 64'd1);
		queue_req(kolt_pkg::KIND_DEL_NAME, 8'd1, 32'd1, 64'd1);
		queue_req(kolt_pkg::KIND_FIND_KEY, 8'd1, 32'd1, 64'd1);
		queue_req(kolt_pkg::KIND_FIND_NAME, 8'd1, 32'd1, 64'd1);
		queue_req(kolt_pkg::KIND_READ, 8'd1, 32'd0, 64'd0);
		queue_req(kolt_pkg::KIND_CLEAR, 8'd0, 32'd0, 64'd0);
		queue_req(kolt_pkg::KIND_INSERT, 8'd0, 32'd9, 64'd9);
		queue_req(kolt_pkg::KIND_INSERT, 8'd2, 32'd9, 64'd9);
		queue_req(kolt_pkg::KIND_INSERT, 8'd1, 32'd0, 64'd0);
		queue_req(kolt_pkg::KIND_APPEND, 8'd0, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
		queue_req(kolt_pkg::KIND_APPEND, 8'd0, 32'd0, 64'd3);
		queue_req(kolt_pkg::KIND_INSERT, 8'd3, 32'hFFFF_FFFF, 64'd4);
		queue_req(kolt_pkg::KIND_INSERT, 8'd255, 32'd11, 64'd5);
		queue_req(kolt_pkg::KIND_INSERT, 8'd1, 32'h5555_5555, 64'hA5A5_5A5A_0F0F_F0F0);
		queue_req(kolt_pkg::KIND_READ, 8'd0, 32'd0, 64'd0);
		queue_req(kolt_pkg::KIND_READ, 8'd4, 32'd0, 64'd0);
		queue_req(kolt_pkg::KIND_READ, 8'd3, 32'd0, 64'd0);
		queue_req(kolt_pkg::KIND_FIND_KEY, 8'd0, 32'hFFFF_FFFF, 64'd0);
		queue_req(kolt_pkg::KIND_FIND_NAME, 8'd0, 32'd0, 64'd0);
		queue_req(kolt_pkg::KIND_FIND_KEY, 8'd0, 32'h0000_1234, 64'd0);
		queue_req(kolt_pkg::KIND_DEL_NAME, 8'd0, 32'd0, 64'hA5A5_5A5A_0F0F_F0F0);
		queue_req(kolt_pkg::KIND_DEL_KEY, 8'd0, 32'd0, 64'd0);
		queue_req(kolt_pkg::KIND_DEL_KEY, 8'd0, 32'd77, 64'd0);
		queue_req(kolt_pkg::KIND_APPEND, 8'd0, 32'd7, 64'hFFFF_FFFF_FFFF_FFFF);
		queue_req(kolt_pkg::KIND_FIND_NAME, 8'd0, 32'd0, 64'hFFFF_FFFF_FFFF_FFFF);

		// zero capacity, a small one, then one lowered below the count
		write_capacity(8'd0);
		queue_req(kolt_pkg::KIND_APPEND, 8'd0, 32'd21, 64'd21);
		queue_req(kolt_pkg::KIND_INSERT, 8'd200, 32'd22, 64'd22);
		write_capacity(8'd2);
		queue_req(kolt_pkg::KIND_CLEAR, 8'd0, 32'd0, 64'd0);
		queue_req(kolt_pkg::KIND_APPEND, 8'd0, 32'd31, 64'd31);
		queue_req(kolt_pkg::KIND_APPEND, 8'd0, 32'd32, 64'd32);
		queue_req(kolt_pkg::KIND_APPEND, 8'd0, 32'd33, 64'd33);
		write_capacity(8'd1);
		queue_req(kolt_pkg::KIND_INSERT, 8'd1, 32'd34, 64'd34);
		queue_req(kolt_pkg::KIND_READ, 8'd2, 32'd0, 64'd0);

		write_capacity(8'd128);
		plan_random(180, 1'b1);
		write_capacity(8'd255);
		plan_random(50, 1'b1);
		write_capacity(8'd40);
		plan_random(90, 1'b0);
		write_capacity(8'($urandom_range(1, 127)));
		plan_random(90, 1'b0);

		drain();
		repeat (TAIL) @(posedge clk);
		if (expected_rsp_q.size() != 0) begin
			$display("%0t: %0d responses never arrived", $time, expected_rsp_q.size());
			error_count++;
		end
		$display("%0d requests checked over %0d capacity writes, longest list %0d entries",
			checked_total, capacity_writes, longest_list);
		$display("status ok %0d full %0d dup %0d bad position %0d empty %0d not found %0d",
			status_seen[kolt_pkg::STATUS_OK], status_seen[kolt_pkg::STATUS_FULL],
			status_seen[kolt_pkg::STATUS_DUP_KEY], status_seen[kolt_pkg::STATUS_BAD_POS],
			status_seen[kolt_pkg::STATUS_EMPTY], status_seen[kolt_pkg::STATUS_NOT_FOUND]);
		if (error_count == 0)
			$display("keyed_ordered_list_table test passed");
		else
			$display("keyed_ordered_list_table test failed");
		$finish;
	end

endmodule
